@@ src/rstt_pkg.sv @@
// Shared types and constants for the trinary remote-socket transmitter.
// No dependencies; compile first.
`default_nettype none

package rstt_pkg;

    // Field and register widths
    localparam int FRAME_BITS  = 12;
    localparam int BIT_POS_W   = 4;
    localparam int CHIP_POS_W  = 6;
    localparam int REPEAT_W    = 8;
    localparam int CHIP_TICK_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CHANNEL_W   = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHIP_TICKS   = 2'd1;

    // Item function codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    // Frame layout
    localparam logic [2:0] FRAME_PAD = 3'b110;
    localparam logic [3:0] NIBBLE_NONE = 4'hf;

    // Slot 12 is the sync slot; data slots hold 8 chips, sync 33 chips
    localparam logic [BIT_POS_W-1:0]  SYNC_SLOT  = 4'd12;
    localparam logic [CHIP_POS_W-1:0] DATA_CHIPS = 6'd8;
    localparam logic [CHIP_POS_W-1:0] SYNC_CHIPS = 6'd33;

    // Chip patterns, chip c at bit c: one = 10001110, zero = 10001000
    localparam logic [7:0] CHIPS_ONE  = 8'b0111_0001;
    localparam logic [7:0] CHIPS_ZERO = 8'b0001_0001;

    localparam logic [REPEAT_W-1:0]    REPEAT_RESET = 8'd4;
    localparam logic [CHIP_TICK_W-1:0] TICKS_RESET  = 16'd1;

    // Sequencer position handed to the chip level decoder
    typedef struct packed {
        logic                  active;
        logic [FRAME_BITS-1:0] frame;
        logic [BIT_POS_W-1:0]  bit_pos;
        logic [CHIP_POS_W-1:0] chip_pos;
    } seq_state_t;

    // One-cold select nibble; out-of-range numbers select nothing
    function automatic logic [3:0] one_cold(input logic [CHANNEL_W-1:0] n);
        logic [3:0] res;
        begin
            unique case (n)
                3'd1:    res = 4'b1110;
                3'd2:    res = 4'b1101;
                3'd3:    res = 4'b1011;
                3'd4:    res = 4'b0111;
                default: res = NIBBLE_NONE;
            endcase
            return res;
        end
    endfunction

endpackage

`default_nettype wire

@@ src/rstt_if.sv @@
// Channel interfaces for the trinary remote-socket transmitter: input items,
// result items and configuration writes. Depends on rstt_pkg.
`default_nettype none

interface rstt_in_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [rstt_pkg::CHANNEL_W-1:0] channel;
    logic [rstt_pkg::CHANNEL_W-1:0] button;
    logic                           switch_on;

    modport source (output valid, output func, output channel, output button,
                    output switch_on, input ready);
    modport sink   (input valid, input func, input channel, input button,
                    input switch_on, output ready);
endinterface

interface rstt_out_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic busy_res;
    logic last_chip;

    modport source (output valid, output pin_level, output busy_res,
                    output last_chip, input ready);
    modport sink   (input valid, input pin_level, input busy_res,
                    input last_chip, output ready);
endinterface

interface rstt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rstt_pkg::CFG_INDEX_W-1:0] index;
    logic [rstt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/remote_socket_trinary_transmitter_core.sv @@
// Trinary remote-socket transmitter core: top level with sequencer state,
// configuration registers and result register. Depends on rstt_pkg,
// rstt_if and rstt_chip_level.
//
// An input transfer's result is in the output register in the cycle after the transfer.
// Throughput: 1 item per cycle; the sequencer update for one item is a single
// pass of logic, so tick items from a free-running timebase are taken
// every clock while the output side keeps up.
// Reset: rst_n (async, active low) returns to idle, repeat_count 4,
// chip_ticks 1, output register empty.
`default_nettype none

module remote_socket_trinary_transmitter_core #(
    parameter int TICK_WIDTH = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    rstt_in_if.sink           item_in,
    rstt_out_if.source        result_out,
    rstt_cfg_if.sink          cfg
);

    localparam int TW = TICK_WIDTH;

    // Configuration registers
    logic [rstt_pkg::REPEAT_W-1:0]    repeat_count_reg;
    logic [rstt_pkg::CHIP_TICK_W-1:0] chip_ticks_reg;

    // Sequencer state
    logic                            active_reg,  active_next;
    logic [rstt_pkg::FRAME_BITS-1:0] frame_reg,   frame_next;
    logic [rstt_pkg::REPEAT_W-1:0]   repeats_reg, repeats_next;
    logic [rstt_pkg::BIT_POS_W-1:0]  bit_pos_reg, bit_pos_next;
    logic [rstt_pkg::CHIP_POS_W-1:0] chip_pos_reg, chip_pos_next;
    logic [TW-1:0]                   tick_reg,    tick_next;

    // Output register
    logic out_valid_reg, out_valid_next;
    logic pin_level_reg, pin_level_next;
    logic busy_reg,      busy_next;
    logic last_reg,      last_next;

    rstt_pkg::seq_state_t seq_cur;
    logic                 cur_level;
    logic                 accept;
    logic                 start_idle;
    logic [31:0]          ticks_ext;
    logic [TW-1:0]        limit;
    logic [TW:0]          tick_inc;
    logic [rstt_pkg::CHIP_POS_W-1:0] chip_inc;
    logic [rstt_pkg::REPEAT_W-1:0]   repeats_dec;

    // Configuration writes are taken every cycle.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_count_reg <= rstt_pkg::REPEAT_RESET;
            chip_ticks_reg   <= rstt_pkg::TICKS_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == rstt_pkg::REG_REPEAT_COUNT)
            begin
                repeat_count_reg <= cfg.data[rstt_pkg::REPEAT_W-1:0];
            end
            else if (cfg.index == rstt_pkg::REG_CHIP_TICKS)
            begin
                chip_ticks_reg <= cfg.data;
            end
        end
    end

    // Current chip level from the present position
    assign seq_cur.active   = active_reg;
    assign seq_cur.frame    = frame_reg;
    assign seq_cur.bit_pos  = bit_pos_reg;
    assign seq_cur.chip_pos = chip_pos_reg;

    rstt_chip_level u_chip_level (
        .seq   (seq_cur),
        .level (cur_level)
    );

    // Take a new item whenever the output register is free or drains now.
    assign item_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = item_in.valid && item_in.ready;
    assign start_idle    = (item_in.func == rstt_pkg::FUNC_START) && !active_reg;

    // Chip length in ticks, fitted to the tick counter; zero counts as one
    assign ticks_ext = {{(32 - rstt_pkg::CHIP_TICK_W){1'b0}}, chip_ticks_reg};
    always_comb
    begin
        limit = ticks_ext[TW-1:0];
        if (limit == '0)
        begin
            limit = {{(TW - 1){1'b0}}, 1'b1};
        end
    end

    assign tick_inc    = {1'b0, tick_reg} + {{TW{1'b0}}, 1'b1};
    assign chip_inc    = chip_pos_reg + 6'd1;
    assign repeats_dec = repeats_reg - 8'd1;

    always_comb
    begin
        active_next    = active_reg;
        frame_next     = frame_reg;
        repeats_next   = repeats_reg;
        bit_pos_next   = bit_pos_reg;
        chip_pos_next  = chip_pos_reg;
        tick_next      = tick_reg;
        out_valid_next = out_valid_reg;
        pin_level_next = pin_level_reg;
        busy_next      = busy_reg;
        last_next      = last_reg;

        if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
            last_next      = 1'b0;
            if (item_in.func == rstt_pkg::FUNC_START)
            begin
                // A start while busy is dropped; the result shows the current chip.
                if (start_idle)
                begin
                    frame_next    = {item_in.switch_on, rstt_pkg::FRAME_PAD,
                                     rstt_pkg::one_cold(item_in.button),
                                     rstt_pkg::one_cold(item_in.channel)};
                    repeats_next  = (repeat_count_reg == '0) ? 8'd1 : repeat_count_reg;
                    bit_pos_next  = '0;
                    chip_pos_next = '0;
                    tick_next     = '0;
                    active_next   = 1'b1;
                end
                // First chip of every bit pattern is high.
                pin_level_next = start_idle ? 1'b1 : cur_level;
                busy_next      = 1'b1;
            end
            else
            begin
                // Tick: report the chip before advancing.
                pin_level_next = cur_level;
                busy_next      = active_reg;
                if (active_reg)
                begin
                    if (tick_inc >= {1'b0, limit})
                    begin
                        tick_next     = '0;
                        chip_pos_next = chip_inc;
                        if (bit_pos_reg < rstt_pkg::SYNC_SLOT)
                        begin
                            if (chip_inc >= rstt_pkg::DATA_CHIPS)
                            begin
                                chip_pos_next = '0;
                                bit_pos_next  = bit_pos_reg + 4'd1;
                            end
                        end
                        else if (chip_inc >= rstt_pkg::SYNC_CHIPS)
                        begin
                            // End of sync: next repetition or done
                            chip_pos_next = '0;
                            bit_pos_next  = '0;
                            repeats_next  = repeats_dec;
                            if (repeats_dec == '0)
                            begin
                                active_next = 1'b0;
                                last_next   = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        tick_next = tick_inc[TW-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            frame_reg     <= '0;
            repeats_reg   <= '0;
            bit_pos_reg   <= '0;
            chip_pos_reg  <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            frame_reg     <= frame_next;
            repeats_reg   <= repeats_next;
            bit_pos_reg   <= bit_pos_next;
            chip_pos_reg  <= chip_pos_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        pin_level_reg <= pin_level_next;
        busy_reg      <= busy_next;
        last_reg      <= last_next;
    end

    assign result_out.valid     = out_valid_reg;
    assign result_out.pin_level = pin_level_reg;
    assign result_out.busy_res  = busy_reg;
    assign result_out.last_chip = last_reg;

endmodule

`default_nettype wire

@@ src/rstt_chip_level.sv @@
// Chip level decoder: maps sequencer position and frame to the pin level.
// Depends on rstt_pkg.
`default_nettype none

module rstt_chip_level (
    input  var rstt_pkg::seq_state_t seq,
    output logic                     level
);

    logic [rstt_pkg::FRAME_BITS-1:0] shifted;
    logic                            data_bit;
    logic [7:0]                      pattern;

    always_comb
    begin
        shifted  = seq.frame >> seq.bit_pos;
        data_bit = shifted[0];
        pattern  = data_bit ? rstt_pkg::CHIPS_ONE : rstt_pkg::CHIPS_ZERO;
        if (!seq.active)
        begin
            level = 1'b0;
        end
        else if (seq.bit_pos >= rstt_pkg::SYNC_SLOT)
        begin
            // sync: one high chip, then low
            level = (seq.chip_pos == '0);
        end
        else
        begin
            level = pattern[seq.chip_pos[2:0]];
        end
    end

endmodule

`default_nettype wire

@@ test/tb_remote_socket_trinary_transmitter_core.sv @@
// Self-checking testbench for remote_socket_trinary_transmitter_core: directed script,
// then randomized command streams checked against an in-bench transmitter predictor.
// Depends on rstt_pkg, rstt_if and the core RTL.
`timescale 1ns / 1ps

module tb_remote_socket_trinary_transmitter_core;

    // Package constants used here, under local names
    localparam logic FUNC_TICK   = rstt_pkg::FUNC_TICK;
    localparam logic FUNC_START  = rstt_pkg::FUNC_START;
    localparam int   CFG_INDEX_W = rstt_pkg::CFG_INDEX_W;
    localparam int   CFG_DATA_W  = rstt_pkg::CFG_DATA_W;
    localparam int   CHANNEL_W   = rstt_pkg::CHANNEL_W;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_COUNT = rstt_pkg::REG_REPEAT_COUNT;
    localparam logic [CFG_INDEX_W-1:0] REG_CHIP_TICKS   = rstt_pkg::REG_CHIP_TICKS;

    // Frame geometry as the encoder sends it: 12 data slots of 8 chips, then a
    // sync slot of one high chip and 32 low chips.
    localparam int         DATA_SLOTS  = 12;
    localparam int         DATA_LEN    = 8;
    localparam int         SYNC_LEN    = 33;
    localparam logic [2:0] PAD_BITS    = 3'b110;
    // Chip c of a data slot sits at bit c: a one is 1000_1110, a zero 1000_1000
    localparam logic [7:0] ONE_CHIPS   = 8'b0111_0001;
    localparam logic [7:0] ZERO_CHIPS  = 8'b0001_0001;

    localparam int QUIET_LIMIT = 2000;  // cycles with no transfer before giving up
    localparam int HOLD_CYCLES = 64;    // receiver hold-off in the pressure phase
    localparam int TAIL_CYCLES = 8;     // settle time after the last result

    typedef struct packed {
        logic                 func;
        logic [CHANNEL_W-1:0] channel;
        logic [CHANNEL_W-1:0] button;
        logic                 switch_on;
    } remote_cmd_t;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic last_chip;
    } pin_sample_t;

    typedef enum logic [1:0] { ROW_CMD, ROW_REG, ROW_DRAIN } row_kind_t;

    // One line of the directed script. A command row is sent count times; where
    // typed is set, the listed sample replaces the predicted one.
    typedef struct packed {
        row_kind_t              kind;
        remote_cmd_t            cmd;
        logic [15:0]            count;
        logic                   typed;
        pin_sample_t            want;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_data;
    } script_row_t;

    typedef enum int { IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH } idle_mode_t;

    localparam int SCRIPT_LEN = 24;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // kind     func        ch    btn   on     count  typed want   reg index        data
        '{ROW_CMD,  {FUNC_TICK,  3'd0, 3'd0, 1'b0}, 16'd1,   1'b1, 3'b000, REG_REPEAT_COUNT, 16'd0},
        '{ROW_REG,  {FUNC_TICK,  3'd0, 3'd0, 1'b0}, 16'd0,   1'b0, 3'b000, REG_REPEAT_COUNT, 16'd0},
        '{ROW_REG,  {FUNC_TICK,  3'd0, 3'd0, 1'b0}, 16'd0,   1'b0, 3'b000, REG_CHIP_TICKS,   16'd0},
        '{ROW_CMD,  {FUNC_START, 3'd1, 3'd1, 1'b1}, 16'd1,   1'b1, 3'b110, REG_REPEAT_COUNT, 16'd0},
        '{ROW_CMD,  {FUNC_START, 3'd4, 3'd4, 1'b0}, 16'd1,   1'b1, 3'b110, REG_REPEAT_COUNT, 16'd0},
        '{ROW_CMD,  {FUNC_TICK,  3'd7, 3'd7, 1'b1}, 16'd128, 1'b0, 3'b000, REG_REPEAT_COUNT, 16'd0},
        '{ROW_CMD,  {FUNC_TICK,  3'd0, 3'd0, 1'b0}, 16'd1,   1'b1, 3'b011, REG_REPEAT_COUNT, 16'd0},
        '{ROW_CMD,  {FUNC_TICK,  3'd0, 3'd0, 1'b0}, 16'd1,   1'b1, 3'b000, REG_REPEAT_COUNT, 16'd0},
        '{ROW_CMD,  {FUNC_START, 3'd0, 3'd7, 1'b1}, 16'd1,   1'b1, 3'b110, REG_REPEAT_COUNT, 16'd0},
        '{ROW_DRAIN,{FUNC_TICK,  3'd0, 3'd0, 1'b0}, 16'd0,   1'b0, 3'b000, REG_REPEAT_COUNT, 16'd0},
        '{ROW_CMD,  {FUNC_START, 3'd5, 3'd0, 1'b0}, 16'd1,   1'b1, 3'b110, REG_REPEAT_COUNT, 16'd0},
        '{ROW_DRAIN,{FUNC_TICK,  3'd0, 3'd0, 1'b0}, 16'd0,   1'b0, 3'b000, REG_REPEAT_COUNT, 16'd0},
        '{ROW_REG,  {FUNC_TICK,  3'd0, 3'd0, 1'b0}, 16'd0,   1'b0, 3'b000, REG_CHIP_TICKS,   16'hffff},
        '{ROW_CMD,  {FUNC_START, 3'd2, 3'd3, 1'b0}, 16'd1,   1'b1, 3'b110, REG_REPEAT_COUNT, 16'd0},
        '{ROW_CMD,  {FUNC_TICK,  3'd0, 3'd0, 1'b0}, 16'd40,  1'b0, 3'b000, REG_REPEAT_COUNT, 16'd0},
        '{ROW_REG,  {FUNC_TICK,  3'd0, 3'd0, 1'b0}, 16'd0,   1'b0, 3'b000, REG_CHIP_TICKS,   16'd2},
        '{ROW_DRAIN,{FUNC_TICK,  3'd0, 3'd0, 1'b0}, 16'd0,   1'b0, 3'b000, REG_REPEAT_COUNT, 16'd0},
        '{ROW_REG,  {FUNC_TICK,  3'd0, 3'd0, 1'b0}, 16'd0,   1'b0, 3'b000, REG_CHIP_TICKS,   16'd1},
        '{ROW_REG,  {FUNC_TICK,  3'd0, 3'd0, 1'b0}, 16'd0,   1'b0, 3'b000, REG_REPEAT_COUNT, 16'd2},
        '{ROW_CMD,  {FUNC_START, 3'd3, 3'd2, 1'b1}, 16'd1,   1'b1, 3'b110, REG_REPEAT_COUNT, 16'd0},
        '{ROW_REG,  {FUNC_TICK,  3'd0, 3'd0, 1'b0}, 16'd0,   1'b0, 3'b000, REG_REPEAT_COUNT, 16'd1},
        '{ROW_DRAIN,{FUNC_TICK,  3'd0, 3'd0, 1'b0}, 16'd0,   1'b0, 3'b000, REG_REPEAT_COUNT, 16'd0},
        '{ROW_CMD,  {FUNC_START, 3'd6, 3'd6, 1'b1}, 16'd1,   1'b1, 3'b110, REG_REPEAT_COUNT, 16'd0},
        '{ROW_DRAIN,{FUNC_TICK,  3'd0, 3'd0, 1'b0}, 16'd0,   1'b0, 3'b000, REG_REPEAT_COUNT, 16'd0}
    };

    // Random phases: repeat count, chip length, idling and number of commands
    localparam int         PHASES         = 6;
    localparam int         PRESSURE_PHASE = 4;
    localparam int         PHASE_REPS  [PHASES] = '{1, 2, 1, 3, 1, 4};
    localparam int         PHASE_TICKS [PHASES] = '{1, 1, 2, 1, 1, 3};
    localparam int         PHASE_ITEMS [PHASES] = '{40, 40, 40, 50, 30, 40};
    localparam idle_mode_t PHASE_MODE  [PHASES] =
        '{IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH, IDLE_NONE, IDLE_BOTH};

    logic clk;
    logic rst_n;

    rstt_in_if  item_if ();
    rstt_out_if res_if ();
    rstt_cfg_if cfg_if ();

    remote_socket_trinary_transmitter_core #(
        .TICK_WIDTH (16)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (res_if),
        .cfg        (cfg_if)
    );

    // Predictor state: latched frame and sequencer position, plus register copies
    logic [11:0] tx_frame;
    logic [7:0]  tx_reps_left;
    logic [3:0]  tx_slot;
    logic [5:0]  tx_chip;
    logic [15:0] tx_ticks;
    logic        tx_active;
    logic [7:0]  reg_repeat;
    logic [15:0] reg_chip_ticks;

    pin_sample_t samples_due [$];   // pin samples predicted, oldest first

    int  src_idle_pct   = 0;
    int  sink_stall_pct = 0;
    bit  hold_req       = 1'b0;
    int  holds_done     = 0;
    int  commands_sent  = 0;
    int  starts_taken   = 0;
    int  results_seen   = 0;
    int  frames_done    = 0;
    int  mismatches     = 0;
    int  quiet_cycles   = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Select nibble with the chosen line pulled low; anything outside 1-4 selects none
    function automatic logic [3:0] cold_nibble(input logic [CHANNEL_W-1:0] n);
        logic [3:0] v;
        v = 4'b1111;
        if (n >= 3'd1 && n <= 3'd4)
            v[n - 3'd1] = 1'b0;
        return v;
    endfunction

    // Level of the chip the sequencer currently points at
    function automatic logic pin_now();
        logic [7:0] pattern;
        if (!tx_active)
            return 1'b0;
        if (tx_slot >= DATA_SLOTS)
            return tx_chip == 6'd0;
        pattern = tx_frame[tx_slot] ? ONE_CHIPS : ZERO_CHIPS;
        return pattern[tx_chip[2:0]];
    endfunction

    task automatic reset_model();
        tx_frame       = '0;
        tx_reps_left   = '0;
        tx_slot        = '0;
        tx_chip        = '0;
        tx_ticks       = '0;
        tx_active      = 1'b0;
        reg_repeat     = 8'd4;
        reg_chip_ticks = 16'd1;
    endtask

    // Advance the predictor by one command and return the sample it produces.
    // A start reports the state after latching; a tick reports the state before
    // it moves the sequencer.
    task automatic transmit_step(input remote_cmd_t c, output pin_sample_t r);
        int lim;
        r = '0;
        if (c.func == FUNC_START && !tx_active) begin
            tx_frame     = {c.switch_on, PAD_BITS, cold_nibble(c.button),
                            cold_nibble(c.channel)};
            tx_reps_left = (reg_repeat == 8'd0) ? 8'd1 : reg_repeat;
            tx_slot      = '0;
            tx_chip      = '0;
            tx_ticks     = '0;
            tx_active    = 1'b1;
            starts_taken++;
        end
        r.pin_level = pin_now();
        r.busy_res  = tx_active;
        if (c.func == FUNC_TICK && tx_active) begin
            lim = (reg_chip_ticks == 16'd0) ? 1 : int'(reg_chip_ticks);
            if (int'(tx_ticks) + 1 >= lim) begin
                tx_ticks = '0;
                tx_chip  = tx_chip + 6'd1;
                if (tx_slot < DATA_SLOTS) begin
                    if (tx_chip >= DATA_LEN) begin
                        tx_chip = '0;
                        tx_slot = tx_slot + 4'd1;
                    end
                end else if (tx_chip >= SYNC_LEN) begin
                    // End of sync: wrap to the first slot, drop one repeat
                    tx_chip      = '0;
                    tx_slot      = '0;
                    tx_reps_left = tx_reps_left - 8'd1;
                    if (tx_reps_left == 8'd0) begin
                        tx_active   = 1'b0;
                        r.last_chip = 1'b1;
                    end
                end
            end else begin
                tx_ticks = tx_ticks + 16'd1;
            end
        end
    endtask

    // Tick with random content in the fields the core ignores on a tick
    function automatic remote_cmd_t filler_tick();
        remote_cmd_t c;
        c.func      = FUNC_TICK;
        c.channel   = CHANNEL_W'($urandom_range(7));
        c.button    = CHANNEL_W'($urandom_range(7));
        c.switch_on = 1'($urandom_range(1));
        return c;
    endfunction

    // Mostly ticks; starts come soon after the transmitter goes idle, and now and
    // then while busy so the ignore path keeps getting hit.
    function automatic remote_cmd_t pick_cmd();
        remote_cmd_t c;
        int          start_pct;
        c         = filler_tick();
        start_pct = tx_active ? 3 : 35;
        if ($urandom_range(99) < start_pct) begin
            c.func    = FUNC_START;
            c.channel = ($urandom_range(9) == 0) ? CHANNEL_W'($urandom_range(7))
                                                 : CHANNEL_W'($urandom_range(4, 1));
            c.button  = ($urandom_range(9) == 0) ? CHANNEL_W'($urandom_range(7))
                                                 : CHANNEL_W'($urandom_range(4, 1));
        end
        return c;
    endfunction

    task automatic set_idle(input idle_mode_t mode);
        unique case (mode)
            IDLE_SRC:  begin src_idle_pct = 52; sink_stall_pct = 0;  end
            IDLE_SINK: begin src_idle_pct = 0;  sink_stall_pct = 52; end
            IDLE_BOTH: begin src_idle_pct = 27; sink_stall_pct = 27; end
            default:   begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        endcase
    endtask

    // Offer one command, hold it until the core takes it, then log the sample it
    // should produce. Call at a rising edge; returns at the edge of the transfer.
    task automatic offer_cmd(input remote_cmd_t c, input bit typed,
                             input pin_sample_t want);
        pin_sample_t got;
        while ($urandom_range(99) < src_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid     <= 1'b1;
        item_if.func      <= c.func;
        item_if.channel   <= c.channel;
        item_if.button    <= c.button;
        item_if.switch_on <= c.switch_on;
        @(posedge clk);
        while (item_if.ready !== 1'b1)
            @(posedge clk);
        transmit_step(c, got);
        samples_due.push_back(typed ? want : got);
        commands_sent++;
    endtask

    // Drop valid and wait for every outstanding sample; returns at a rising edge
    task automatic settle();
        item_if.valid <= 1'b0;
        @(negedge clk);
        while (samples_due.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1)
            @(posedge clk);
        if (idx == REG_REPEAT_COUNT)
            reg_repeat = data[7:0];
        else if (idx == REG_CHIP_TICKS)
            reg_chip_ticks = data[15:0];
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic want,
                                        input logic got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
        end
    endfunction

    // Receiver: stall at the phase's rate; on request, hold off for a long stretch
    // so the core backs up into its input.
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare every result transfer with the oldest predicted sample
    always @(posedge clk) begin
        pin_sample_t want;
        if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            results_seen++;
            if (res_if.last_chip === 1'b1)
                frames_done++;
            if (samples_due.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected, actual pin %0b busy %0b last %0b",
                         $time, res_if.pin_level, res_if.busy_res, res_if.last_chip);
            end else begin
                want = samples_due.pop_front();
                check_field("pin_level", want.pin_level, res_if.pin_level);
                check_field("busy_res",  want.busy_res,  res_if.busy_res);
                check_field("last_chip", want.last_chip, res_if.last_chip);
            end
        end
    end

    // Watchdog: end the run once no channel has moved a transfer for too long
    always @(posedge clk) begin
        if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
            (res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
            (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d samples outstanding",
                     $time, QUIET_LIMIT, samples_due.size());
            $display("tb_remote_socket_trinary_transmitter_core: errors");
            $finish;
        end
    end

    initial begin
        script_row_t row;

        rst_n             <= 1'b0;
        item_if.valid     <= 1'b0;
        item_if.func      <= FUNC_TICK;
        item_if.channel   <= '0;
        item_if.button    <= '0;
        item_if.switch_on <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= REG_REPEAT_COUNT;
        cfg_if.data       <= '0;
        reset_model();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script: idle output, zero registers, busy starts, out-of-range
        // selects, chip length changed mid-chip, several repeats with the repeat
        // count rewritten mid-transmission.
        set_idle(IDLE_NONE);
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            row = SCRIPT[i];
            unique case (row.kind)
                ROW_REG: begin
                    settle();
                    write_reg(row.reg_index, row.reg_data);
                end
                ROW_DRAIN: begin
                    while (tx_active)
                        offer_cmd(filler_tick(), 1'b0, '0);
                end
                default: begin
                    repeat (row.count)
                        offer_cmd(row.cmd, row.typed, row.want);
                end
            endcase
        end

        // Random phases; each writes both registers once the core's results have drained
        for (int p = 0; p < PHASES; p++) begin
            settle();
            set_idle(PHASE_MODE[p]);
            write_reg(REG_REPEAT_COUNT, {8'($urandom_range(255)), 8'(PHASE_REPS[p])});
            write_reg(REG_CHIP_TICKS, CFG_DATA_W'(PHASE_TICKS[p]));
            if (p == PRESSURE_PHASE)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS[p])
                offer_cmd(pick_cmd(), 1'b0, '0);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d commands and %0d samples: %0d frames latched, %0d sent out",
                 commands_sent, results_seen, starts_taken, frames_done);
        $display("receiver hold-offs: %0d, mismatches: %0d, samples left over: %0d",
                 holds_done, mismatches, samples_due.size());
        if (mismatches == 0 && samples_due.size() == 0)
            $display("tb_remote_socket_trinary_transmitter_core: clean");
        else
            $display("tb_remote_socket_trinary_transmitter_core: errors");
        $finish;
    end

endmodule
